>>> design/drum_voice_synth_defines.svh
// Assertion macros shared by the drum voice synth RTL.
`ifndef DRUM_VOICE_SYNTH_DEFINES_SVH
`define DRUM_VOICE_SYNTH_DEFINES_SVH
`ifndef ASSERT_OFF
`define DVS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("drum voice synth assertion failed");
`define DVS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drum voice synth assertion failed");
`else
`define DVS_ASSERT(name, clk, rst, prop)
`define DVS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> design/dvs_pkg.sv
// Types and constants shared by the drum voice synth modules.
package dvs_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENV_LEVEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENV_SLOPE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_ONE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TWO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_ZERO   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_ONE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TWO    = 3'd6;

   localparam logic [1:0] CODE_KEEP   = 2'd0;
   localparam logic [1:0] CODE_NEGATE = 2'd1;
   localparam logic [1:0] CODE_DOUBLE = 2'd2;
   localparam logic [1:0] CODE_HALVE  = 2'd3;

   // operand selects of the shared multiplier
   localparam int MUL_SEL_W = 3;
   localparam logic [MUL_SEL_W-1:0] TERM_B0   = 3'd0;
   localparam logic [MUL_SEL_W-1:0] TERM_B1   = 3'd1;
   localparam logic [MUL_SEL_W-1:0] TERM_B2   = 3'd2;
   localparam logic [MUL_SEL_W-1:0] TERM_A1   = 3'd3;
   localparam logic [MUL_SEL_W-1:0] TERM_A2   = 3'd4;
   localparam logic [MUL_SEL_W-1:0] TERM_GAIN = 3'd5;

   localparam logic signed [15:0] CLAMP_HI = 16'sd127;
   localparam logic signed [15:0] CLAMP_LO = -16'sd128;
   localparam logic signed [7:0]  Y_HI     = 8'sd127;
   localparam logic signed [7:0]  Y_LO     = -8'sd128;
   localparam logic [7:0]         GAIN_SAT = 8'd255;

   typedef struct packed {
      logic                 load;
      logic                 prep;
      logic                 mul_en;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic                 acc_clr;
      logic                 acc_en;
      logic                 acc_sub;
      logic                 gain;
      logic                 finish;
   } dvs_cmd_type;

endpackage

>>> design/dvs_req_if.sv
// Input sample channel of the drum voice synth.
interface dvs_req_if;
   logic              valid;
   logic              ready;
   logic              restart;
   logic signed [7:0] noise;
   logic              dither_bit;
   logic              bass_valid;
   logic [1:0]        bass_code;

   modport source (output valid, restart, noise, dither_bit, bass_valid, bass_code,
                   input ready);
   modport sink   (input valid, restart, noise, dither_bit, bass_valid, bass_code,
                   output ready);
endinterface

>>> design/dvs_rsp_if.sv
// Result channel of the drum voice synth.
interface dvs_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] mix_sample;
   logic              bass_on;
   logic              treble_on;

   modport source (output valid, mix_sample, bass_on, treble_on, input ready);
   modport sink   (input valid, mix_sample, bass_on, treble_on, output ready);
endinterface

>>> design/dvs_csr_if.sv
// Register write channel of the drum voice synth.
interface dvs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dvs_pkg::CSR_IDX_W-1:0]  index;
   logic [dvs_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/dvs_ctrl.sv
// Sequencer for the drum voice synth: steps one item through the datapath.
`include "drum_voice_synth_defines.svh"

module dvs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output dvs_pkg::dvs_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_GAIN = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [dvs_pkg::MUL_SEL_W-1:0] cnt_ff, cnt_in;
   logic                           out_full_ff, out_full_in;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      out_full_in = out_full_ff && !rsp_ready;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep    = 1'b1;
            cmd.acc_clr = 1'b1;
            cnt_in      = dvs_pkg::TERM_B0;
            state_in    = S_MUL;
         end
         S_MUL: begin
            // issue one product, fold in the one registered last cycle
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cnt_ff;
            cmd.acc_en  = (cnt_ff != dvs_pkg::TERM_B0);
            cmd.acc_sub = (cnt_ff == dvs_pkg::TERM_A2);
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == dvs_pkg::TERM_A2) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_sub = 1'b1;
            state_in    = S_GAIN;
         end
         S_GAIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dvs_pkg::TERM_GAIN;
            cmd.gain    = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!out_full_ff || rsp_ready) begin
               cmd.finish  = 1'b1;
               out_full_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         out_full_ff <= out_full_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_full_ff;

   `DVS_ASSERT(a_finish_slot_free, clock, reset, cmd.finish |-> (!out_full_ff || rsp_ready))
   `DVS_ASSERT_NEXT(a_load_to_prep, clock, reset, cmd.load, state_ff == S_PREP)
   `DVS_ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, rsp_valid && state_ff == S_IDLE)
   `DVS_ASSERT(a_cnt_bound, clock, reset, (state_ff == S_MUL) |-> (cnt_ff <= dvs_pkg::TERM_A2))

endmodule

>>> design/dvs_datapath.sv
// Datapath of the drum voice synth: voice state, registers, shared multiplier.
module dvs_datapath #(
   parameter int BLOCK_LOG2 = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dvs_pkg::dvs_cmd_type           cmd,
   input  logic                           req_restart,
   input  logic signed [7:0]              req_noise,
   input  logic                           req_dither_bit,
   input  logic                           req_bass_valid,
   input  logic [1:0]                     req_bass_code,
   input  logic                           csr_we,
   input  logic [dvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dvs_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed [8:0]              rsp_mix_sample,
   output logic                           rsp_bass_on,
   output logic                           rsp_treble_on
);

   // configuration
   logic [15:0]        env_start_level_ff, env_start_slope_ff;
   logic signed [15:0] fb_coef_one_ff, fb_coef_two_ff;
   logic signed [7:0]  ff_coef_zero_ff, ff_coef_one_ff, ff_coef_two_ff;

   // item held while it is worked on
   logic              restart_ff, dither_ff, bass_valid_ff;
   logic signed [7:0] noise_ff;
   logic [1:0]        bass_code_ff;

   // voice state
   logic [7:0]            recon_last_ff, recon_last_in;
   logic [7:0]            recon_prev_ff, recon_prev_in;
   logic [7:0]            delta_mod_ff, delta_mod_in;
   logic [7:0]            bass_now_ff, bass_now_in;
   logic [7:0]            bass_before_ff, bass_before_in;
   logic [15:0]           ramp_acc_ff, ramp_acc_in;
   logic [BLOCK_LOG2-1:0] sample_pos_ff, sample_pos_in;
   logic                  bass_active_ff, bass_active_in;
   logic signed [7:0]     filt_in_hist_ff [2];
   logic signed [7:0]     filt_in_hist_in [2];
   logic signed [7:0]     filt_out_hist_ff [2];
   logic signed [7:0]     filt_out_hist_in [2];
   logic [31:0]           env_level_ff, env_level_in;
   logic [31:0]           env_half_ff, env_half_in;
   logic [31:0]           env_slope_ff, env_slope_in;
   logic [7:0]            treble_gain_ff, treble_gain_in;

   // arithmetic
   logic signed [15:0] mul_a;
   logic signed [8:0]  mul_b;
   logic signed [24:0] mul_p;
   logic signed [24:0] prod_ff;
   logic signed [15:0] acc_ff, acc_in;
   logic [15:0]        term;
   logic signed [7:0]  y_clamp;
   logic               treble_now;
   logic signed [16:0] ramp_ext, ramp_sh, ramp_sum, bass_v;
   logic [15:0]        mix_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         env_start_level_ff <= '0;
         env_start_slope_ff <= '0;
         fb_coef_one_ff     <= '0;
         fb_coef_two_ff     <= '0;
         ff_coef_zero_ff    <= '0;
         ff_coef_one_ff     <= '0;
         ff_coef_two_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dvs_pkg::CSR_ENV_LEVEL: env_start_level_ff <= csr_data;
            dvs_pkg::CSR_ENV_SLOPE: env_start_slope_ff <= csr_data;
            dvs_pkg::CSR_FB_ONE:    fb_coef_one_ff     <= csr_data;
            dvs_pkg::CSR_FB_TWO:    fb_coef_two_ff     <= csr_data;
            dvs_pkg::CSR_FF_ZERO:   ff_coef_zero_ff    <= csr_data[7:0];
            dvs_pkg::CSR_FF_ONE:    ff_coef_one_ff     <= csr_data[7:0];
            dvs_pkg::CSR_FF_TWO:    ff_coef_two_ff     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // shared 16x9 multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         dvs_pkg::TERM_B0: begin
            mul_a = {{8{ff_coef_zero_ff[7]}}, ff_coef_zero_ff};
            mul_b = {noise_ff[7], noise_ff};
         end
         dvs_pkg::TERM_B1: begin
            mul_a = {{8{ff_coef_one_ff[7]}}, ff_coef_one_ff};
            mul_b = {filt_in_hist_ff[0][7], filt_in_hist_ff[0]};
         end
         dvs_pkg::TERM_B2: begin
            mul_a = {{8{ff_coef_two_ff[7]}}, ff_coef_two_ff};
            mul_b = {filt_in_hist_ff[1][7], filt_in_hist_ff[1]};
         end
         dvs_pkg::TERM_A1: begin
            mul_a = fb_coef_one_ff;
            mul_b = {filt_out_hist_ff[0][7], filt_out_hist_ff[0]};
         end
         dvs_pkg::TERM_A2: begin
            mul_a = fb_coef_two_ff;
            mul_b = {filt_out_hist_ff[1][7], filt_out_hist_ff[1]};
         end
         dvs_pkg::TERM_GAIN: begin
            mul_a = {{8{y_clamp[7]}}, y_clamp};
            mul_b = {1'b0, treble_gain_ff};
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // product shifted right by 8, wrapped to 16 bits
   assign term = prod_ff[23:8];

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = cmd.acc_sub ? acc_ff - term : acc_ff + term;
      end
   end

   always_comb begin
      if (acc_ff > dvs_pkg::CLAMP_HI) begin
         y_clamp = dvs_pkg::Y_HI;
      end else if (acc_ff < dvs_pkg::CLAMP_LO) begin
         y_clamp = dvs_pkg::Y_LO;
      end else begin
         y_clamp = acc_ff[7:0];
      end
   end

   assign treble_now = (env_level_ff != '0);

   // bass interpolation sample
   assign ramp_ext = {ramp_acc_ff[15], ramp_acc_ff};
   assign ramp_sh  = ramp_ext >>> (BLOCK_LOG2 - 1);
   assign ramp_sum = ramp_sh + $signed({16'd0, dither_ff});
   assign bass_v   = ramp_sum >>> 1;

   always_comb begin
      mix_sum = (bass_active_ff ? bass_v[15:0] : 16'd0)
              + (treble_now ? {{7{prod_ff[16]}}, prod_ff[16:8]} : 16'd0);
   end

   always_comb begin : next_voice
      logic [7:0]  mod_new;
      logic [7:0]  recon;
      logic [15:0] level_hi;
      logic [8:0]  step;
      logic [31:0] slope_n;
      logic [31:0] half_b;

      recon_last_in       = recon_last_ff;
      recon_prev_in       = recon_prev_ff;
      delta_mod_in        = delta_mod_ff;
      bass_now_in         = bass_now_ff;
      bass_before_in      = bass_before_ff;
      ramp_acc_in         = ramp_acc_ff;
      sample_pos_in       = sample_pos_ff;
      bass_active_in      = bass_active_ff;
      filt_in_hist_in[0]  = filt_in_hist_ff[0];
      filt_in_hist_in[1]  = filt_in_hist_ff[1];
      filt_out_hist_in[0] = filt_out_hist_ff[0];
      filt_out_hist_in[1] = filt_out_hist_ff[1];
      env_level_in        = env_level_ff;
      env_half_in         = env_half_ff;
      env_slope_in        = env_slope_ff;
      treble_gain_in      = treble_gain_ff;
      mod_new             = delta_mod_ff;
      recon               = '0;
      level_hi            = '0;
      step                = '0;
      slope_n             = env_slope_ff;
      half_b              = env_half_ff;

      if (cmd.prep) begin
         if (restart_ff) begin
            recon_last_in       = '0;
            recon_prev_in       = '0;
            delta_mod_in        = '0;
            bass_now_in         = '0;
            bass_before_in      = '0;
            ramp_acc_in         = '0;
            sample_pos_in       = '0;
            filt_in_hist_in[0]  = '0;
            filt_in_hist_in[1]  = '0;
            filt_out_hist_in[0] = '0;
            filt_out_hist_in[1] = '0;
            treble_gain_in      = '0;
            env_level_in        = {env_start_level_ff, 16'd0};
            env_half_in         = {1'b0, env_start_level_ff, 15'd0};
            env_slope_in        = {15'd0, env_start_slope_ff, 1'b0};
            bass_active_in      = 1'b1;
         end
         if (sample_pos_in == '0) begin
            if (bass_active_in && bass_valid_ff) begin
               unique case (bass_code_ff)
                  dvs_pkg::CODE_KEEP:   mod_new = delta_mod_in;
                  dvs_pkg::CODE_NEGATE: mod_new = 8'd0 - delta_mod_in;
                  dvs_pkg::CODE_DOUBLE:
                     mod_new = (delta_mod_in == '0) ? 8'd1 : {delta_mod_in[6:0], 1'b0};
                  dvs_pkg::CODE_HALVE:
                     mod_new = (delta_mod_in == '0) ? 8'hFF
                                                    : {delta_mod_in[7], delta_mod_in[7:1]};
                  default: mod_new = delta_mod_in;
               endcase
               // second-order predictor, wraps at 8 bits
               recon          = {recon_last_in[6:0], 1'b0} - recon_prev_in + mod_new;
               delta_mod_in   = mod_new;
               recon_prev_in  = recon_last_in;
               recon_last_in  = recon;
               bass_before_in = bass_now_in;
               bass_now_in    = recon;
               ramp_acc_in    = {{8{bass_before_in[7]}}, bass_before_in} << BLOCK_LOG2;
            end else begin
               bass_active_in = 1'b0;
            end
            if (env_level_in != '0) begin
               level_hi       = env_level_in[31:16];
               treble_gain_in = (level_hi[15:8] != '0) ? dvs_pkg::GAIN_SAT : level_hi[7:0];
            end
         end
      end

      if (cmd.gain && treble_now) begin
         filt_in_hist_in[1]  = filt_in_hist_ff[0];
         filt_in_hist_in[0]  = noise_ff;
         filt_out_hist_in[1] = filt_out_hist_ff[0];
         filt_out_hist_in[0] = y_clamp;
      end

      if (cmd.finish) begin
         if (bass_active_ff) begin
            step        = {bass_now_ff[7], bass_now_ff} - {bass_before_ff[7], bass_before_ff};
            ramp_acc_in = ramp_acc_ff + {{7{step[8]}}, step};
         end
         if (treble_now && (&sample_pos_ff)) begin
            // slope halves once the half-level mark is passed
            if (env_half_ff < env_slope_ff) begin
               half_b  = {1'b0, env_level_ff[31:1]};
               slope_n = {1'b0, env_slope_ff[31:1]};
            end
            env_slope_in = slope_n;
            env_level_in = env_level_ff - slope_n;
            env_half_in  = half_b - slope_n;
         end
         sample_pos_in = sample_pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recon_last_ff       <= '0;
         recon_prev_ff       <= '0;
         delta_mod_ff        <= '0;
         bass_now_ff         <= '0;
         bass_before_ff      <= '0;
         ramp_acc_ff         <= '0;
         sample_pos_ff       <= '0;
         bass_active_ff      <= 1'b0;
         filt_in_hist_ff[0]  <= '0;
         filt_in_hist_ff[1]  <= '0;
         filt_out_hist_ff[0] <= '0;
         filt_out_hist_ff[1] <= '0;
         env_level_ff        <= '0;
         env_half_ff         <= '0;
         env_slope_ff        <= '0;
         treble_gain_ff      <= '0;
      end else begin
         recon_last_ff       <= recon_last_in;
         recon_prev_ff       <= recon_prev_in;
         delta_mod_ff        <= delta_mod_in;
         bass_now_ff         <= bass_now_in;
         bass_before_ff      <= bass_before_in;
         ramp_acc_ff         <= ramp_acc_in;
         sample_pos_ff       <= sample_pos_in;
         bass_active_ff      <= bass_active_in;
         filt_in_hist_ff[0]  <= filt_in_hist_in[0];
         filt_in_hist_ff[1]  <= filt_in_hist_in[1];
         filt_out_hist_ff[0] <= filt_out_hist_in[0];
         filt_out_hist_ff[1] <= filt_out_hist_in[1];
         env_level_ff        <= env_level_in;
         env_half_ff         <= env_half_in;
         env_slope_ff        <= env_slope_in;
         treble_gain_ff      <= treble_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         restart_ff    <= req_restart;
         noise_ff      <= req_noise;
         dither_ff     <= req_dither_bit;
         bass_valid_ff <= req_bass_valid;
         bass_code_ff  <= req_bass_code;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      acc_ff <= acc_in;
      if (cmd.finish) begin
         rsp_mix_sample <= mix_sum[8:0];
         rsp_bass_on    <= bass_active_ff;
         rsp_treble_on  <= treble_now;
      end
   end

endmodule

>>> design/drum_voice_synth.sv
// Top level of the drum voice synth: sequencer plus datapath.
//
//   channel   port     direction   carries
//   input     req_ch   in          restart, noise, dither_bit, bass_valid, bass_code
//   result    rsp_ch   out         mix_sample, bass_on, treble_on
//   register  csr_ch   in          index, data (always ready)
//
// One item is worked on at a time and the next is accepted only when idle: the single
// 16x9 multiplier runs six products in turn (five filter taps and the gain).
// A finished result waits in the output register; the next item is worked on
// meanwhile and holds in its last step only while that register is still full.
// Reset clears the voice state and the configuration registers to zero; no clearing pass.
module drum_voice_synth #(
   parameter int BLOCK_LOG2 = 4
) (
   input  logic       clock,
   input  logic       reset,
   dvs_req_if.sink    req_ch,
   dvs_rsp_if.source  rsp_ch,
   dvs_csr_if.sink    csr_ch
);

   dvs_pkg::dvs_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   dvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   dvs_datapath #(
      .BLOCK_LOG2 (BLOCK_LOG2)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_restart    (req_ch.restart),
      .req_noise      (req_ch.noise),
      .req_dither_bit (req_ch.dither_bit),
      .req_bass_valid (req_ch.bass_valid),
      .req_bass_code  (req_ch.bass_code),
      .csr_we         (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .rsp_mix_sample (rsp_ch.mix_sample),
      .rsp_bass_on    (rsp_ch.bass_on),
      .rsp_treble_on  (rsp_ch.treble_on)
   );

endmodule
